// ----- hw/rtl/sud_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sud_pkg
// Shared types and constants for the set union/difference/intersection block.
// ----------------------------------------------------------------------------
package sud_pkg;

    localparam int SET_SIZE_DEF = 8;
    localparam int VALUE_W      = 32;
    localparam int LIST_W       = 2;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [LIST_W-1:0]         list_t;

    localparam list_t LIST_UNION = 2'd0;
    localparam list_t LIST_DIFF  = 2'd1;
    localparam list_t LIST_INTER = 2'd2;

    // Control from the sequencer to one row of cells
    typedef struct packed {
        logic shift;   // push a new word in at cell 0
        logic clear;   // empty the row
    } chain_ctrl_t;

endpackage : sud_pkg
`default_nettype wire

// ----- hw/rtl/sud_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sud_cell
// One storage cell: holds a word and its valid flag, takes its neighbor's
// contents on a shift and compares its word against the broadcast key.
// ----------------------------------------------------------------------------
module sud_cell
    import sud_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire chain_ctrl_t ctrl,
    input  wire value_t      prev_value,
    input  wire logic        prev_valid,
    input  wire value_t      key,
    output value_t           value,
    output logic             valid,
    output logic             match
);

    value_t value_reg;
    logic   valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            value_reg <= prev_value;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (value_reg == key);

endmodule : sud_cell
`default_nettype wire

// ----- hw/rtl/sud_chain.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sud_chain
// A row of cells forming one set. New words enter at cell 0 and push the
// older ones up, so the oldest entry sits at the highest occupied cell.
// ----------------------------------------------------------------------------
module sud_chain
    import sud_pkg::*;
#(
    parameter int SET_SIZE = SET_SIZE_DEF,
    localparam int IDX_W   = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire chain_ctrl_t      ctrl,
    input  wire value_t           din,
    input  wire value_t           key,
    input  wire logic [IDX_W-1:0] idx,
    output value_t                sel_value,
    output logic [SET_SIZE-1:0]   match,
    output logic                  full
);

    value_t              cell_value [SET_SIZE];
    logic [SET_SIZE-1:0] cell_valid;

    for (genvar i = 0; i < SET_SIZE; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            sud_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_value (din),
                .prev_valid (1'b1),
                .key        (key),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .match      (match[i])
            );
        end
        else
        begin : g_body
            sud_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_value (cell_value[i-1]),
                .prev_valid (cell_valid[i-1]),
                .key        (key),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .match      (match[i])
            );
        end
    end

    assign sel_value = cell_value[idx];
    assign full      = cell_valid[SET_SIZE-1];

endmodule : sud_chain
`default_nettype wire

// ----- hw/rtl/set_union_difference_intersection.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// set_union_difference_intersection
// Two small sets of signed words with union, difference and intersection.
// ----------------------------------------------------------------------------
// Each input transaction stores one word into set A (to_second_set = 0) or
// set B (to_second_set = 1); a word arriving at a full set is dropped. Loads
// may follow back to back while the block is idle. The transaction marked
// last is stored too, then the block scans both sets and emits three lists,
// tagged by list_id: the union (A's entries, then B's), the difference A
// minus B and the intersection, each in order of first arrival with
// duplicates removed. The last result of the run carries last_of_run, after
// which both sets are empty. Each set is a row of cells; the scan broadcasts
// one candidate per cycle, unless the result side stalls, to every cell of
// both rows, which compare in parallel. No input is taken during the scan.
// An output register and one held-back result decouple the result side; the
// held-back result is what lets the final one be flagged.
// ----------------------------------------------------------------------------
module set_union_difference_intersection
    import sud_pkg::*;
#(
    parameter int SET_SIZE = SET_SIZE_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    output logic        item_ready,
    input  wire value_t value,
    input  wire logic   to_second_set,
    input  wire logic   last,
    output logic        res_valid,
    input  wire logic   res_ready,
    output value_t      value_res,
    output list_t       list_id,
    output logic        last_of_run
);

    localparam int CNT_W = $clog2(SET_SIZE + 1);
    localparam int IDX_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNI_A,
        ST_UNI_B,
        ST_DIFF,
        ST_INTER,
        ST_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg, cnt_b_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // Output register and the held-back result
    value_t out_value_reg, out_value_next;
    list_t  out_list_reg, out_list_next;
    logic   out_last_reg, out_last_next;
    logic   out_valid_reg, out_valid_next;
    value_t pend_value_reg, pend_value_next;
    list_t  pend_list_reg, pend_list_next;
    logic   pend_valid_reg, pend_valid_next;

    chain_ctrl_t         ctrl_a, ctrl_b;
    value_t              sel_a, sel_b, key;
    logic [SET_SIZE-1:0] match_a, match_b, above;
    logic                full_a, full_b;

    logic             accept, load_a, load_b, out_free;
    logic             dup_a, in_a, dup_b, in_b;
    logic             cand, hit, can_step;
    logic [CNT_W-1:0] cnt_cur, cnt_a_m1, cnt_b_m1;
    list_t            cur_list;

    // ---- set storage -------------------------------------------------------
    sud_chain #(.SET_SIZE(SET_SIZE)) u_chain_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_a),
        .din       (value),
        .key       (key),
        .idx       (idx_reg),
        .sel_value (sel_a),
        .match     (match_a),
        .full      (full_a)
    );

    sud_chain #(.SET_SIZE(SET_SIZE)) u_chain_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_b),
        .din       (value),
        .key       (key),
        .idx       (idx_reg),
        .sel_value (sel_b),
        .match     (match_b),
        .full      (full_b)
    );

    // ---- load path ---------------------------------------------------------
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign load_a     = accept && !to_second_set && !full_a;
    assign load_b     = accept &&  to_second_set && !full_b;

    // Empty both rows as the sequencer leaves the flush state
    assign ctrl_a.shift = load_a;
    assign ctrl_b.shift = load_b;
    assign ctrl_a.clear = (state_reg == ST_FLUSH) && (!pend_valid_reg || out_free);
    assign ctrl_b.clear = ctrl_a.clear;

    // ---- membership tests --------------------------------------------------
    // Cells above the scan index hold older entries of the same set.
    always_comb
    begin
        for (int i = 0; i < SET_SIZE; i++)
        begin
            above[i] = (IDX_W'(i) > idx_reg);
        end
    end

    assign key   = (state_reg == ST_UNI_B) ? sel_b : sel_a;
    assign dup_a = |(match_a & above);
    assign in_a  = |match_a;
    assign dup_b = |(match_b & above);
    assign in_b  = |match_b;

    assign cnt_cur  = (state_reg == ST_UNI_B) ? cnt_b_reg : cnt_a_reg;
    assign cand     = (cnt_cur != '0);
    assign out_free = !out_valid_reg || res_ready;
    assign cnt_a_m1 = cnt_a_reg - 1'b1;
    assign cnt_b_m1 = cnt_b_reg - 1'b1;

    always_comb
    begin
        hit      = 1'b0;
        cur_list = LIST_UNION;
        unique case (state_reg)
            ST_UNI_A:
            begin
                hit = !dup_a;
            end
            ST_UNI_B:
            begin
                hit = !in_a && !dup_b;
            end
            ST_DIFF:
            begin
                hit      = !dup_a && !in_b;
                cur_list = LIST_DIFF;
            end
            ST_INTER:
            begin
                hit      = !dup_a && in_b;
                cur_list = LIST_INTER;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
        hit = hit && cand;
    end

    // Stall the scan only when a new result needs the output register
    assign can_step = !hit || !pend_valid_reg || out_free;

    // ---- sequencer ---------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        idx_next        = idx_reg;
        out_value_next  = out_value_reg;
        out_list_next   = out_list_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        pend_value_next = pend_value_reg;
        pend_list_next  = pend_list_reg;
        pend_valid_next = pend_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_a_next = cnt_a_reg + CNT_W'(load_a);
                cnt_b_next = cnt_b_reg + CNT_W'(load_b);
                if (accept && last)
                begin
                    state_next = ST_UNI_A;
                    idx_next   = IDX_W'(cnt_a_next - 1'b1);
                end
            end
            ST_UNI_A, ST_UNI_B, ST_DIFF, ST_INTER:
            begin
                if (can_step)
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_value_next = pend_value_reg;
                            out_list_next  = pend_list_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_value_next = key;
                        pend_list_next  = cur_list;
                        pend_valid_next = 1'b1;
                    end
                    if (!cand || (idx_reg == '0))
                    begin
                        // Advance to the next list phase
                        unique case (state_reg)
                            ST_UNI_A:
                            begin
                                state_next = ST_UNI_B;
                                idx_next   = cnt_b_m1[IDX_W-1:0];
                            end
                            ST_UNI_B:
                            begin
                                state_next = ST_DIFF;
                                idx_next   = cnt_a_m1[IDX_W-1:0];
                            end
                            ST_DIFF:
                            begin
                                state_next = ST_INTER;
                                idx_next   = cnt_a_m1[IDX_W-1:0];
                            end
                            default:
                            begin
                                state_next = ST_FLUSH;
                            end
                        endcase
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_value_next  = pend_value_reg;
                        out_list_next   = pend_list_reg;
                        out_last_next   = 1'b1;
                        out_valid_next  = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload holds without reset
    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_list_reg   <= out_list_next;
        out_last_reg   <= out_last_next;
        pend_value_reg <= pend_value_next;
        pend_list_reg  <= pend_list_next;
    end

    assign res_valid   = out_valid_reg;
    assign value_res   = out_value_reg;
    assign list_id     = out_list_reg;
    assign last_of_run = out_last_reg;

endmodule : set_union_difference_intersection
`default_nettype wire

// ----- hw/rtl/sud_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sud_checker
// Port-level checks for set_union_difference_intersection.
// ----------------------------------------------------------------------------
module sud_checker
    import sud_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    input  wire logic   item_ready,
    input  wire logic   last,
    input  wire logic   res_valid,
    input  wire logic   res_ready,
    input  wire value_t value_res,
    input  wire list_t  list_id,
    input  wire logic   last_of_run
);

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(value_res)
            && $stable(list_id) && $stable(last_of_run))
        else $error("result changed while stalled");

    // A last transaction starts the scan, so input is blocked next cycle
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && last |=> !item_ready)
        else $error("input taken during scan");

    // Only the final result may wait while loading is open
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready && res_valid |-> last_of_run)
        else $error("non-final result pending while idle");

    a_list_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (list_id == LIST_UNION) || (list_id == LIST_DIFF)
            || (list_id == LIST_INTER))
        else $error("bad list code");

endmodule : sud_checker

bind set_union_difference_intersection sud_checker u_sud_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .last        (last),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .value_res   (value_res),
    .list_id     (list_id),
    .last_of_run (last_of_run)
);
`default_nettype wire
